[rtl/core/odct_pkg.sv]
// ----------------------------------------------------------------------------
// odct_pkg: shared types and constants for the orthonormal DCT engine
// Frame size, datapath widths, sequencer states and the basis ROM.
// ----------------------------------------------------------------------------
package odct_pkg;

   localparam int POINTS   = 8;
   localparam int IDX_W    = $clog2(POINTS);
   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 18;
   localparam int KIDX_W   = 3;
   localparam int PROD_W   = 32;
   localparam int ACC_W    = PROD_W + IDX_W + 1;
   localparam int FRAC_W   = 15;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_MAC,
      ST_FLUSH,
      ST_ROUND
   } state_type;

   typedef logic signed [SAMPLE_W-1:0] rom_word_type;

   // alpha(k) * cos((2n+1)*k*pi/16) in Q1.15, row k, column n
   localparam rom_word_type BASIS_ROM [0:POINTS*POINTS-1] = '{
       16'sd11585,  16'sd11585,  16'sd11585,  16'sd11585,
       16'sd11585,  16'sd11585,  16'sd11585,  16'sd11585,
       16'sd16069,  16'sd13623,  16'sd9102,   16'sd3196,
      -16'sd3196,  -16'sd9102,  -16'sd13623, -16'sd16069,
       16'sd15137,  16'sd6270,  -16'sd6270,  -16'sd15137,
      -16'sd15137, -16'sd6270,   16'sd6270,   16'sd15137,
       16'sd13623, -16'sd3196,  -16'sd16069, -16'sd9102,
       16'sd9102,   16'sd16069,  16'sd3196,  -16'sd13623,
       16'sd11585, -16'sd11585, -16'sd11585,  16'sd11585,
       16'sd11585, -16'sd11585, -16'sd11585,  16'sd11585,
       16'sd9102,  -16'sd16069,  16'sd3196,   16'sd13623,
      -16'sd13623, -16'sd3196,   16'sd16069, -16'sd9102,
       16'sd6270,  -16'sd15137,  16'sd15137, -16'sd6270,
      -16'sd6270,   16'sd15137, -16'sd15137,  16'sd6270,
       16'sd3196,  -16'sd9102,   16'sd13623, -16'sd16069,
       16'sd16069, -16'sd13623,  16'sd9102,  -16'sd3196
   };

endpackage

[rtl/core/odct_ram.sv]
// ----------------------------------------------------------------------------
// odct_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module odct_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/orthonormal_dct_engine.sv]
// ----------------------------------------------------------------------------
// orthonormal_dct_engine: 8-point orthonormal DCT-II, one shared MAC
// Loads a frame of samples, then emits the rounded, saturated coefficients.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake          payload
//  -------  ---  -----------------  ------------------------------------------
//  req      in   req_tvalid/tready  tdata[15:0] sample
//  rsp      out  rsp_tvalid/tready  tdata[17:0] coefficient, [20:18] index,
//                                   tlast = last coefficient of the frame
//
//  A sample request is taken each cycle while loading. After the eighth one
//  the single multiplier walks the sample RAM read port: for each coefficient
//  the sequencer passes through the MAC, flush and round states in order,
//  and after the last coefficient of the frame it returns to loading.
//  Reset is synchronous, active high; it clears the sequencer, counters and
//  output valid, not the sample store. A stalled rsp holds the sequencer in
//  the round state; the final coefficient may wait while the next frame loads.
//
module orthonormal_dct_engine (
   input  logic        clock,
   input  logic        reset,
   // req
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample
   // rsp
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [17:0] coefficient, [20:18] coefficient_index
   output logic        rsp_tlast    // last_of_frame
);

   localparam int IW = odct_pkg::IDX_W;
   localparam int AW = odct_pkg::ACC_W;
   localparam int FW = odct_pkg::FRAC_W;
   localparam int RW = AW - FW;

   odct_pkg::state_type state_ff, state_in;

   logic [IW-1:0] load_count_ff, load_count_in;
   logic [IW-1:0] k_ff, k_in;
   logic [IW-1:0] n_ff, n_in;

   // MAC pipeline: read issue -> product -> accumulate
   logic          rd_vld_ff;
   logic [IW-1:0] rd_n_ff;
   logic          prod_vld_ff;
   logic signed [odct_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [AW-1:0]               acc_ff, acc_in;

   logic                               rsp_vld_ff, rsp_vld_in;
   logic signed [odct_pkg::COEF_W-1:0] coef_ff, coef_in;
   logic [odct_pkg::KIDX_W-1:0]        kidx_ff;
   logic                               last_ff;

   logic req_fire, rsp_free;
   logic issue, acc_clear, emit;
   logic [odct_pkg::SAMPLE_W-1:0] ram_q;
   odct_pkg::rom_word_type        rom_q;

   logic [AW-1:0] mag, mag_rnd;
   logic [RW-1:0] rnd;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_free = !rsp_vld_ff || rsp_tready;

   // --- next state ---
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         odct_pkg::ST_LOAD: begin
            if (req_fire && load_count_ff == IW'(odct_pkg::POINTS - 1)) begin
               state_in = odct_pkg::ST_MAC;
            end
         end
         odct_pkg::ST_MAC: begin
            if (n_ff == IW'(odct_pkg::POINTS - 1)) begin
               state_in = odct_pkg::ST_FLUSH;
            end
         end
         odct_pkg::ST_FLUSH: begin
            if (!rd_vld_ff && !prod_vld_ff) begin
               state_in = odct_pkg::ST_ROUND;
            end
         end
         odct_pkg::ST_ROUND: begin
            if (rsp_free) begin
               state_in = (k_ff == IW'(odct_pkg::POINTS - 1)) ? odct_pkg::ST_LOAD
                                                              : odct_pkg::ST_MAC;
            end
         end
         default: state_in = odct_pkg::ST_LOAD;
      endcase
   end

   // --- sequencer outputs ---
   always_comb begin
      req_tready = 1'b0;
      issue      = 1'b0;
      acc_clear  = 1'b0;
      emit       = 1'b0;
      unique case (state_ff)
         odct_pkg::ST_LOAD: begin
            req_tready = 1'b1;
            acc_clear  = 1'b1;
         end
         odct_pkg::ST_MAC: begin
            issue = 1'b1;
         end
         odct_pkg::ST_FLUSH: begin
         end
         odct_pkg::ST_ROUND: begin
            emit      = rsp_free;
            acc_clear = rsp_free;
         end
         default: begin
         end
      endcase
   end

   // --- counters ---
   always_comb begin
      load_count_in = load_count_ff;
      k_in          = k_ff;
      n_in          = n_ff;
      if (req_fire) begin
         load_count_in = (load_count_ff == IW'(odct_pkg::POINTS - 1)) ? '0
                                                                      : load_count_ff + 1'b1;
      end
      if (issue) begin
         n_in = n_ff + 1'b1;
      end
      if (emit) begin
         n_in = '0;
         k_in = (k_ff == IW'(odct_pkg::POINTS - 1)) ? '0 : k_ff + 1'b1;
      end
   end

   // sample store
   odct_ram #(
      .WIDTH (odct_pkg::SAMPLE_W),
      .DEPTH (odct_pkg::POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (load_count_ff),
      .wr_data (req_tdata),
      .rd_en   (issue),
      .rd_addr (n_ff),
      .rd_data (ram_q)
   );

   // shared multiply-accumulate
   assign rom_q   = odct_pkg::BASIS_ROM[{k_ff, rd_n_ff}];
   assign prod_in = $signed(ram_q) * rom_q;

   always_comb begin
      acc_in = acc_ff;
      if (acc_clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + AW'(prod_ff);
      end
   end

   // round half away from zero, then clamp to 18 bits
   assign mag     = acc_ff[AW-1] ? AW'(-acc_ff) : AW'(acc_ff);
   assign mag_rnd = mag + AW'(1 << (FW - 1));
   assign rnd     = mag_rnd[AW-1:FW];

   always_comb begin
      if (acc_ff[AW-1]) begin
         coef_in = (rnd > RW'(131072)) ? -18'sd131072 : -($signed(rnd[17:0]));
      end else begin
         coef_in = (rnd > RW'(131071)) ? 18'sd131071 : $signed(rnd[17:0]);
      end
   end

   assign rsp_vld_in = emit || (rsp_vld_ff && !rsp_tready);

   // --- control registers ---
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= odct_pkg::ST_LOAD;
         load_count_ff <= '0;
         k_ff          <= '0;
         n_ff          <= '0;
         rd_vld_ff     <= 1'b0;
         prod_vld_ff   <= 1'b0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         k_ff          <= k_in;
         n_ff          <= n_in;
         rd_vld_ff     <= issue;
         prod_vld_ff   <= rd_vld_ff;
         rsp_vld_ff    <= rsp_vld_in;
      end
   end

   // --- datapath registers ---
   always_ff @(posedge clock) begin
      rd_n_ff <= n_ff;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (emit) begin
         coef_ff <= coef_in;
         kidx_ff <= odct_pkg::KIDX_W'(k_ff);
         last_ff <= (k_ff == IW'(odct_pkg::POINTS - 1));
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {3'b000, kidx_ff, coef_ff};
   assign rsp_tlast  = last_ff;

   // --- assertions ---
   a_pipe_in_mac: assert property (@(posedge clock) disable iff (reset)
      prod_vld_ff |-> (state_ff == odct_pkg::ST_MAC || state_ff == odct_pkg::ST_FLUSH))
      else $error("MAC pipeline active outside compute");

   a_load_count_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != odct_pkg::ST_LOAD) |-> (load_count_ff == '0))
      else $error("load count nonzero during compute");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && last_ff) |-> (kidx_ff == odct_pkg::KIDX_W'(odct_pkg::POINTS - 1)))
      else $error("frame end marked on wrong coefficient");

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for orthonormal_dct_engine
// Streams frames of signed samples through the req channel. A local fixed-point
// DCT-II predicts each frame's coefficients from its own basis table. Every
// rsp request is compared against the oldest expected coefficient.
// ----------------------------------------------------------------------------
module testbench;
   import odct_pkg::*;

   localparam int          IDLE_LIMIT = 1000;  // cycles with no request accepted
   localparam int          TAIL_WAIT  = 150;   // > one frame of compute
   localparam longint      PI_Q30     = 64'sd3373259426;
   localparam longint      ONE_Q30    = 64'sd1 << 30;
   localparam int          TDATA_W    = 24;

   typedef longint unsigned qword_t;
   typedef logic signed [SAMPLE_W-1:0] sample_t;
   typedef sample_t frame_t [POINTS];

   typedef struct packed {
      logic signed [COEF_W-1:0] coefficient;
      logic [KIDX_W-1:0]        index;
      logic                     last;
   } dct_coef_t;

   typedef enum int unsigned {
      RDY_ALWAYS,
      RDY_TWO_OF_THREE,
      RDY_COIN,
      RDY_ONE_OF_EIGHT
   } stall_kind_t;

   typedef enum int unsigned {
      FRAME_NOISE,
      FRAME_SMALL,
      FRAME_FLAT,
      FRAME_IMPULSE,
      FRAME_ALTERNATE,
      FRAME_WIDE
   } frame_kind_t;

   // DUT ports; the inputs driven here are all known from time zero
   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [15:0]         req_tdata  = '0;   // [15:0] sample
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [TDATA_W-1:0]  rsp_tdata;         // [17:0] coefficient, [20:18] coefficient_index
   logic                rsp_tlast;         // last_of_frame

   // basis table alpha(k)*cos(...) in Q1.15, built locally
   int                  basis_q15 [POINTS][POINTS];

   // predictor state: samples of the frame being loaded
   sample_t             frame_samples [POINTS];
   int                  load_pos = 0;

   dct_coef_t           expected_coefs [$];
   dct_coef_t           coef_want;
   int                  mismatch_count = 0;

   // sender burst shaping
   int                  burst_left = 0;
   logic                ready_seen;

   // receiver stall pattern
   stall_kind_t         stall_mode = RDY_ALWAYS;
   int unsigned         stall_left = 0;
   int unsigned         stall_tick = 0;

   orthonormal_dct_engine u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Basis table: fold angle into first quadrant, Q30 Taylor cosine, Q30
   // alpha, then round Q60 -> Q15 half away from zero and clamp to 16 bits.
   // ------------------------------------------------------------------------
   function automatic longint unsigned int_sqrt(input longint unsigned value);
      longint unsigned rem;
      longint unsigned root;
      longint unsigned probe;
      rem   = value;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > rem)
         probe >>= 2;
      while (probe != 0) begin
         if (rem >= root + probe) begin
            rem  = rem - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root >>= 1;
         end
         probe >>= 2;
      end
      return root;
   endfunction

   // cos(pi*m/(2*POINTS)) in Q30
   function automatic longint cos_q30(input int unsigned m_in);
      int unsigned     m;
      bit              negate;
      longint          angle;
      longint unsigned angle_sq;
      longint unsigned term;
      longint          sum;
      m      = m_in % (4 * POINTS);
      negate = 1'b0;
      if (m > 2 * POINTS)
         m = 4 * POINTS - m;
      if (m > POINTS) begin
         m      = 2 * POINTS - m;
         negate = 1'b1;
      end
      angle    = (PI_Q30 * longint'(m) + POINTS) / (2 * POINTS);
      angle_sq = (qword_t'(angle) * qword_t'(angle)) >> 30;
      term     = ONE_Q30;
      sum      = ONE_Q30;
      for (int i = 1; i <= 9; i++) begin
         term = (term * angle_sq) >> 30;
         term = term / qword_t'((2 * i - 1) * (2 * i));
         if (i % 2 == 1)
            sum -= longint'(term);
         else
            sum += longint'(term);
      end
      return negate ? -sum : sum;
   endfunction

   function automatic void build_basis();
      longint          alpha_dc;
      longint          alpha_ac;
      longint          prod;
      longint unsigned mag;
      longint          word;
      alpha_dc = longint'(int_sqrt((64'd1 << 60) / POINTS));
      alpha_ac = longint'(int_sqrt((64'd1 << 61) / POINTS));
      for (int k = 0; k < POINTS; k++) begin
         for (int n = 0; n < POINTS; n++) begin
            prod = (k == 0 ? alpha_dc : alpha_ac) * cos_q30((2 * n + 1) * k);
            mag  = prod < 0 ? qword_t'(-prod) : qword_t'(prod);
            mag  = (mag + (64'd1 << 44)) >> 45;
            word = prod < 0 ? -longint'(mag) : longint'(mag);
            if (word > 32767)
               word = 32767;
            if (word < -32768)
               word = -32768;
            basis_q15[k][n] = int'(word);
         end
      end
   endfunction

   // ------------------------------------------------------------------------
   // Predictor: store the sample; on the frame's last one, push all
   // coefficients rounded half away from zero and clamped to 18 bits.
   // ------------------------------------------------------------------------
   function automatic void predict_sample(input sample_t value);
      longint          acc;
      longint unsigned mag;
      longint          rounded;
      dct_coef_t       coef;
      frame_samples[load_pos] = value;
      if (load_pos < POINTS - 1) begin
         load_pos++;
         return;
      end
      load_pos = 0;
      for (int k = 0; k < POINTS; k++) begin
         acc = 0;
         for (int n = 0; n < POINTS; n++)
            acc += longint'(frame_samples[n]) * longint'(basis_q15[k][n]);
         mag     = acc < 0 ? qword_t'(-acc) : qword_t'(acc);
         mag     = (mag + 16384) >> 15;
         rounded = acc < 0 ? -longint'(mag) : longint'(mag);
         if (rounded > 131071)
            rounded = 131071;
         if (rounded < -131072)
            rounded = -131072;
         coef.coefficient = rounded[COEF_W-1:0];
         coef.index       = k[KIDX_W-1:0];
         coef.last        = (k == POINTS - 1);
         expected_coefs.push_back(coef);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Sender: one sample request. Bursts of random length, random gaps
   // between them, some long bursts with no gap at all. tready is looked at
   // on the falling edge, where it is stable until the next rising edge.
   // ------------------------------------------------------------------------
   task automatic send_sample(input sample_t value);
      int gap;
      if (burst_left == 0) begin
         case ($urandom_range(0, 5))
            0: begin
               gap        = 0;
               burst_left = $urandom_range(16, 40);
            end
            1: begin
               gap        = $urandom_range(20, 40);
               burst_left = $urandom_range(1, 12);
            end
            default: begin
               gap        = $urandom_range(0, 8);
               burst_left = $urandom_range(1, 12);
            end
         endcase
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do begin
         @(negedge clock);
         ready_seen = req_tready;
         @(posedge clock);
      end while (!ready_seen);
      burst_left--;
      predict_sample(value);
   endtask

   task automatic send_frame(input frame_t frame);
      for (int n = 0; n < POINTS; n++)
         send_sample(frame[n]);
   endtask

   task automatic wait_drained();
      while (expected_coefs.size() != 0)
         @(posedge clock);
   endtask

   // sender holds off until every pending coefficient has come back
   task automatic pause_until_drained();
      req_tvalid <= 1'b0;
      wait_drained();
      @(posedge clock);
      burst_left = 0;
   endtask

   function automatic frame_t random_frame(input frame_kind_t kind);
      frame_t  frame;
      int      spot;
      sample_t level;
      bit      phase;
      spot  = $urandom_range(0, POINTS - 1);
      level = ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
      phase = $urandom_range(0, 1);
      for (int n = 0; n < POINTS; n++) begin
         case (kind)
            FRAME_SMALL:     frame[n] = sample_t'($urandom_range(0, 31)) - 16'sd16;
            FRAME_FLAT:      frame[n] = level;
            FRAME_IMPULSE:   frame[n] = '0;
            FRAME_ALTERNATE: frame[n] = ((n % 2) == phase) ? 16'sh7FFF : 16'sh8000;
            default:         frame[n] = sample_t'($urandom);
         endcase
      end
      if (kind == FRAME_IMPULSE) begin
         case ($urandom_range(0, 2))
            0:       frame[spot] = 16'sd16384;
            1:       frame[spot] = -16'sd16384;
            default: frame[spot] = sample_t'($urandom);
         endcase
      end
      return frame;
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // full-scale alternating input drives the highest-frequency terms
   task automatic test_extreme_frames();
      frame_t frame;
      for (int n = 0; n < POINTS; n++)
         frame[n] = (n % 2 == 0) ? 16'sh7FFF : 16'sh8000;
      send_frame(frame);
   endtask

   // an impulse of +/-2^14 at n=0 puts an exact half on every odd basis word
   task automatic test_rounding_ties();
      frame_t frame;
      for (int n = 0; n < POINTS; n++)
         frame[n] = '0;
      frame[0] = 16'sd16384;
      send_frame(frame);
      frame[0] = -16'sd16384;
      send_frame(frame);
   endtask

   // sender stops dead until the engine has drained, then restarts with a fresh burst
   task automatic test_drain_pause();
      send_frame(random_frame(FRAME_NOISE));
      pause_until_drained();
      send_frame(random_frame(FRAME_WIDE));
      pause_until_drained();
   endtask

   task automatic test_random_frames();
      frame_kind_t kind;
      for (int f = 0; f < 34; f++) begin
         kind = frame_kind_t'($urandom_range(0, 5));
         send_frame(random_frame(kind));
         if ($urandom_range(0, 7) == 0)
            pause_until_drained();
      end
   endtask

   // ------------------------------------------------------------------------
   // Receiver: rsp_tready follows a stall pattern that switches now and then
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_kind_t'($urandom_range(0, 3));
         stall_left = $urandom_range(16, 96);
      end else begin
         stall_left--;
      end
      stall_tick++;
      case (stall_mode)
         RDY_ALWAYS:       rsp_tready <= 1'b1;
         RDY_TWO_OF_THREE: rsp_tready <= (stall_tick % 3) != 0;
         RDY_COIN:         rsp_tready <= $urandom_range(0, 1);
         default:          rsp_tready <= (stall_tick % 8) == 0;
      endcase
   end

   task automatic note_mismatch(input string what);
      if (mismatch_count < 10)
         $display("%s", what);
      mismatch_count++;
   endtask

   // Checker: rsp is sampled on the falling edge; the request completes at
   // the following rising edge since tready and tvalid hold until then.
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_coefs.size() == 0) begin
            note_mismatch($sformatf("unexpected coefficient %0d k=%0d last=%0b",
               $signed(rsp_tdata[COEF_W-1:0]), rsp_tdata[COEF_W+KIDX_W-1:COEF_W],
               rsp_tlast));
         end else begin
            coef_want = expected_coefs.pop_front();
            if (rsp_tdata[COEF_W-1:0] !== coef_want.coefficient
                || rsp_tdata[COEF_W+KIDX_W-1:COEF_W] !== coef_want.index
                || rsp_tdata[TDATA_W-1:COEF_W+KIDX_W] !== '0
                || rsp_tlast !== coef_want.last) begin
               note_mismatch($sformatf(
                  "coefficient mismatch: expected %0d k=%0d last=%0b, got %0d k=%0d last=%0b pad=%h",
                  coef_want.coefficient, coef_want.index, coef_want.last,
                  $signed(rsp_tdata[COEF_W-1:0]), rsp_tdata[COEF_W+KIDX_W-1:COEF_W],
                  rsp_tlast, rsp_tdata[TDATA_W-1:COEF_W+KIDX_W]));
            end
         end
      end
   end

   // Watchdog: too long with no request accepted on either channel
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(negedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      build_basis();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extreme_frames();
      test_rounding_ties();
      test_drain_pause();
      test_random_frames();

      req_tvalid <= 1'b0;
      wait_drained();
      repeat (TAIL_WAIT) @(posedge clock);

      if (mismatch_count == 0 && expected_coefs.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/odct_pkg.sv
rtl/core/odct_ram.sv
rtl/core/orthonormal_dct_engine.sv
test/testbench.sv
